// ----- rtl/rdfs_pkg.sv -----
// Shared types, constants and helpers for the rectangle and disc fill scanner.
package rdfs_pkg;

    localparam int DIM_W   = 12;
    localparam int COORD_W = 13;
    localparam int RAD_W   = 11;
    localparam int RSQ_W   = 22;
    localparam int OFF_W   = 23;
    localparam int COLOR_W = 32;
    localparam int SQ_W    = 26;

    localparam logic [DIM_W-1:0] MAX_SIDE     = 12'd2048;
    localparam logic [DIM_W-1:0] WIDTH_RESET  = 12'd640;
    localparam logic [DIM_W-1:0] HEIGHT_RESET = 12'd480;

    typedef enum logic [1:0] {
        ACT_TICK = 2'd0,
        ACT_RECT = 2'd1,
        ACT_DISC = 2'd2
    } t_action;

    typedef enum logic {
        CFG_FRAME_WIDTH  = 1'b0,
        CFG_FRAME_HEIGHT = 1'b1
    } t_cfg_index;

    // One scan position handed from the scan control to the pixel pipeline.
    typedef struct packed {
        logic                      valid;
        logic                      empty;
        logic                      disc;
        logic                      last;
        logic [DIM_W-1:0]          col;
        logic [DIM_W-1:0]          row;
        logic signed [COORD_W-1:0] cx;
        logic signed [COORD_W-1:0] cy;
        logic [RSQ_W-1:0]          rsq;
        logic [COLOR_W-1:0]        color;
    } t_scan_req;

    // Clamp a signed coordinate to [0, hi].
    function automatic logic [DIM_W-1:0] clip_coord(input logic signed [COORD_W:0] v,
                                                    input logic [DIM_W-1:0] hi);
        logic [DIM_W-1:0] res;
        res = v[DIM_W-1:0];
        if (v < 0) begin
            res = '0;
        end else if (v > $signed({2'b00, hi})) begin
            res = hi;
        end
        return res;
    endfunction

endpackage

// ----- rtl/rdfs_pixel_pipe.sv -----
// Two-stage pixel pipeline: offset and squared distances, then disc test and result register.
module rdfs_pixel_pipe (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  rdfs_pkg::t_scan_req            i_req,
    input  logic [rdfs_pkg::DIM_W-1:0]     i_frame_width,
    input  logic                           i_out_stall,
    output logic                           o_hold,
    output logic                           o_out_valid,
    output logic [rdfs_pkg::DIM_W-1:0]     o_pixel_x,
    output logic [rdfs_pkg::DIM_W-1:0]     o_pixel_y,
    output logic [rdfs_pkg::OFF_W-1:0]     o_pixel_offset,
    output logic [rdfs_pkg::COLOR_W-1:0]   o_pixel_color,
    output logic                           o_write_enable,
    output logic                           o_last
);

    logic                               r_a_valid;
    logic                               r_a_keep;
    logic                               r_a_disc;
    logic                               r_a_last;
    logic [rdfs_pkg::DIM_W-1:0]         r_a_x;
    logic [rdfs_pkg::DIM_W-1:0]         r_a_y;
    logic [rdfs_pkg::OFF_W-1:0]         r_a_off;
    logic [rdfs_pkg::COLOR_W-1:0]       r_a_color;
    logic [rdfs_pkg::SQ_W-1:0]          r_a_dx2;
    logic [rdfs_pkg::SQ_W-1:0]          r_a_dy2;
    logic [rdfs_pkg::RSQ_W-1:0]         r_a_rsq;

    logic                               r_o_valid;
    logic [rdfs_pkg::DIM_W-1:0]         r_o_x;
    logic [rdfs_pkg::DIM_W-1:0]         r_o_y;
    logic [rdfs_pkg::OFF_W-1:0]         r_o_off;
    logic [rdfs_pkg::COLOR_W-1:0]       r_o_color;
    logic                               r_o_we;
    logic                               r_o_last;

    logic                               advance;
    logic signed [rdfs_pkg::COORD_W:0]  dx;
    logic signed [rdfs_pkg::COORD_W:0]  dy;
    logic signed [2*rdfs_pkg::COORD_W+1:0] dx2_full;
    logic signed [2*rdfs_pkg::COORD_W+1:0] dy2_full;
    logic [2*rdfs_pkg::DIM_W-1:0]       off_full;
    logic [rdfs_pkg::SQ_W:0]            dist_sum;
    logic                               in_circle;

    assign advance = !r_o_valid || !i_out_stall;
    assign o_hold  = r_a_valid && !advance;

    always_comb begin
        dx       = $signed({2'b00, i_req.col}) - $signed({i_req.cx[rdfs_pkg::COORD_W-1], i_req.cx});
        dy       = $signed({2'b00, i_req.row}) - $signed({i_req.cy[rdfs_pkg::COORD_W-1], i_req.cy});
        dx2_full = $signed({{(rdfs_pkg::COORD_W+1){dx[rdfs_pkg::COORD_W]}}, dx}) *
                   $signed({{(rdfs_pkg::COORD_W+1){dx[rdfs_pkg::COORD_W]}}, dx});
        dy2_full = $signed({{(rdfs_pkg::COORD_W+1){dy[rdfs_pkg::COORD_W]}}, dy}) *
                   $signed({{(rdfs_pkg::COORD_W+1){dy[rdfs_pkg::COORD_W]}}, dy});
        off_full = ({{rdfs_pkg::DIM_W{1'b0}}, i_req.row} *
                    {{rdfs_pkg::DIM_W{1'b0}}, i_frame_width}) +
                   {{rdfs_pkg::DIM_W{1'b0}}, i_req.col};
        dist_sum = {1'b0, r_a_dx2} + {1'b0, r_a_dy2};
        in_circle = dist_sum <= {{(rdfs_pkg::SQ_W+1-rdfs_pkg::RSQ_W){1'b0}}, r_a_rsq};
    end

    // Stage A: products of the current scan position.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
        end else if (i_req.valid) begin
            r_a_valid <= 1'b1;
        end else if (advance) begin
            r_a_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.valid) begin
            r_a_keep  <= !i_req.empty;
            r_a_disc  <= i_req.disc;
            r_a_last  <= i_req.empty || i_req.last;
            r_a_x     <= i_req.empty ? '0 : i_req.col;
            r_a_y     <= i_req.empty ? '0 : i_req.row;
            r_a_off   <= i_req.empty ? '0 : off_full[rdfs_pkg::OFF_W-1:0];
            r_a_color <= i_req.empty ? '0 : i_req.color;
            r_a_dx2   <= dx2_full[rdfs_pkg::SQ_W-1:0];
            r_a_dy2   <= dy2_full[rdfs_pkg::SQ_W-1:0];
            r_a_rsq   <= i_req.rsq;
        end
    end

    // Result register: disc test and hold under stall.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (advance) begin
            r_o_valid <= r_a_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance && r_a_valid) begin
            r_o_x     <= r_a_x;
            r_o_y     <= r_a_y;
            r_o_off   <= r_a_off;
            r_o_color <= r_a_color;
            r_o_we    <= r_a_keep && (!r_a_disc || in_circle);
            r_o_last  <= r_a_last;
        end
    end

    assign o_out_valid    = r_o_valid;
    assign o_pixel_x      = r_o_x;
    assign o_pixel_y      = r_o_y;
    assign o_pixel_offset = r_o_off;
    assign o_pixel_color  = r_o_color;
    assign o_write_enable = r_o_we;
    assign o_last         = r_o_last;

    a_req_fills_stage: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_req.valid |=> r_a_valid)
        else $error("scan request did not reach stage A");

    a_hold_needs_full_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_hold |-> (r_o_valid && i_out_stall && r_a_valid))
        else $error("hold raised without a stalled result");

    a_drain_empties: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_o_valid && !i_out_stall && !r_a_valid) |=> !r_o_valid)
        else $error("result repeated after being taken");

endmodule

// ----- rtl/rect_disc_fill_scanner.sv -----
// Top level of the rectangle and disc fill scanner: configuration, scan control and handshakes.
// A start request (rectangle or disc) loads a clipped bounding box and produces no result; each
// tick request while a primitive is loaded produces one scan position in row-major order, or
// one closing result with nothing written for an empty box. One request is taken per clock and
// one result delivered per clock while no stall holds them. The edge that accepts a tick loads
// the first pipeline register (squared distances and offset); the result register then takes
// it with the disc test. The input stalls only when both pipeline registers are full and the
// output is stalled. Configuration writes are always ready and saturate values above 2048.
module rect_disc_fill_scanner (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_in_valid,
    output logic                               o_in_stall,
    input  logic [1:0]                         i_action,
    input  logic signed [rdfs_pkg::COORD_W-1:0] i_first_x,
    input  logic signed [rdfs_pkg::COORD_W-1:0] i_first_y,
    input  logic signed [rdfs_pkg::COORD_W-1:0] i_second_x,
    input  logic signed [rdfs_pkg::COORD_W-1:0] i_second_y,
    input  logic [rdfs_pkg::RAD_W-1:0]         i_radius,
    input  logic [rdfs_pkg::COLOR_W-1:0]       i_fill_color,
    output logic                               o_out_valid,
    input  logic                               i_out_stall,
    output logic [rdfs_pkg::DIM_W-1:0]         o_pixel_x,
    output logic [rdfs_pkg::DIM_W-1:0]         o_pixel_y,
    output logic [rdfs_pkg::OFF_W-1:0]         o_pixel_offset,
    output logic [rdfs_pkg::COLOR_W-1:0]       o_pixel_color,
    output logic                               o_write_enable,
    output logic                               o_last,
    input  logic                               i_cfg_valid,
    output logic                               o_cfg_ready,
    input  logic                               i_cfg_index,
    input  logic [rdfs_pkg::DIM_W-1:0]         i_cfg_data
);

    logic [rdfs_pkg::DIM_W-1:0]         r_frame_width;
    logic [rdfs_pkg::DIM_W-1:0]         r_frame_height;

    logic                               r_busy;
    logic                               r_disc;
    logic [rdfs_pkg::DIM_W-1:0]         r_scan_col;
    logic [rdfs_pkg::DIM_W-1:0]         r_scan_row;
    logic [rdfs_pkg::DIM_W-1:0]         r_row_start_col;
    logic [rdfs_pkg::DIM_W-1:0]         r_end_col;
    logic [rdfs_pkg::DIM_W-1:0]         r_end_row;
    logic signed [rdfs_pkg::COORD_W-1:0] r_centre_x;
    logic signed [rdfs_pkg::COORD_W-1:0] r_centre_y;
    logic [rdfs_pkg::RSQ_W-1:0]         r_rsq;
    logic [rdfs_pkg::COLOR_W-1:0]       r_color;

    logic                               hold;
    logic                               accept;
    logic                               tick_go;
    logic                               box_empty;
    logic                               col_wrap;
    logic                               row_done;
    logic [rdfs_pkg::DIM_W:0]           col_inc;
    logic [rdfs_pkg::DIM_W:0]           row_inc;
    logic [rdfs_pkg::DIM_W-1:0]         cfg_sat;
    logic signed [rdfs_pkg::COORD_W:0]  ax;
    logic signed [rdfs_pkg::COORD_W:0]  ay;
    logic signed [rdfs_pkg::COORD_W:0]  bx;
    logic signed [rdfs_pkg::COORD_W:0]  by;
    logic [rdfs_pkg::DIM_W-1:0]         n_x0;
    logic [rdfs_pkg::DIM_W-1:0]         n_x1;
    logic [rdfs_pkg::DIM_W-1:0]         n_y0;
    logic [rdfs_pkg::DIM_W-1:0]         n_y1;
    logic [2*rdfs_pkg::RAD_W-1:0]       rsq_full;
    rdfs_pkg::t_scan_req                req;

    assign o_cfg_ready = 1'b1;
    assign o_in_stall  = hold;
    assign accept      = i_in_valid && !hold;
    assign tick_go     = accept && (i_action == rdfs_pkg::ACT_TICK) && r_busy;

    always_comb begin
        cfg_sat = (i_cfg_data > rdfs_pkg::MAX_SIDE) ? rdfs_pkg::MAX_SIDE : i_cfg_data;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_width  <= rdfs_pkg::WIDTH_RESET;
            r_frame_height <= rdfs_pkg::HEIGHT_RESET;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                rdfs_pkg::CFG_FRAME_WIDTH:  r_frame_width  <= cfg_sat;
                rdfs_pkg::CFG_FRAME_HEIGHT: r_frame_height <= cfg_sat;
                default: ;
            endcase
        end
    end

    // Box corners for a start request; a disc spans centre minus and plus radius.
    always_comb begin
        rsq_full = {{rdfs_pkg::RAD_W{1'b0}}, i_radius} * {{rdfs_pkg::RAD_W{1'b0}}, i_radius};
        if (i_action == rdfs_pkg::ACT_DISC) begin
            ax = $signed({i_first_x[rdfs_pkg::COORD_W-1], i_first_x}) -
                 $signed({3'b000, i_radius});
            ay = $signed({i_first_y[rdfs_pkg::COORD_W-1], i_first_y}) -
                 $signed({3'b000, i_radius});
            bx = $signed({i_first_x[rdfs_pkg::COORD_W-1], i_first_x}) +
                 $signed({3'b000, i_radius});
            by = $signed({i_first_y[rdfs_pkg::COORD_W-1], i_first_y}) +
                 $signed({3'b000, i_radius});
        end else begin
            ax = {i_first_x[rdfs_pkg::COORD_W-1], i_first_x};
            ay = {i_first_y[rdfs_pkg::COORD_W-1], i_first_y};
            bx = {i_second_x[rdfs_pkg::COORD_W-1], i_second_x};
            by = {i_second_y[rdfs_pkg::COORD_W-1], i_second_y};
        end
        n_x0 = rdfs_pkg::clip_coord(ax, r_frame_width);
        n_x1 = rdfs_pkg::clip_coord(bx, r_frame_width);
        n_y0 = rdfs_pkg::clip_coord(ay, r_frame_height);
        n_y1 = rdfs_pkg::clip_coord(by, r_frame_height);
    end

    always_comb begin
        col_inc   = {1'b0, r_scan_col} + 1'b1;
        row_inc   = {1'b0, r_scan_row} + 1'b1;
        box_empty = (r_scan_col >= r_end_col) || (r_scan_row >= r_end_row);
        col_wrap  = col_inc >= {1'b0, r_end_col};
        row_done  = row_inc >= {1'b0, r_end_row};

        req.valid = tick_go;
        req.empty = box_empty;
        req.disc  = r_disc;
        req.last  = col_wrap && row_done;
        req.col   = r_scan_col;
        req.row   = r_scan_row;
        req.cx    = r_centre_x;
        req.cy    = r_centre_y;
        req.rsq   = r_rsq;
        req.color = r_color;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy          <= 1'b0;
            r_disc          <= 1'b0;
            r_scan_col      <= '0;
            r_scan_row      <= '0;
            r_row_start_col <= '0;
            r_end_col       <= '0;
            r_end_row       <= '0;
            r_centre_x      <= '0;
            r_centre_y      <= '0;
            r_rsq           <= '0;
            r_color         <= '0;
        end else if (accept) begin
            case (i_action)
                rdfs_pkg::ACT_RECT, rdfs_pkg::ACT_DISC: begin
                    r_busy          <= 1'b1;
                    r_disc          <= (i_action == rdfs_pkg::ACT_DISC);
                    r_color         <= i_fill_color;
                    r_scan_col      <= n_x0;
                    r_row_start_col <= n_x0;
                    r_scan_row      <= n_y0;
                    r_end_col       <= n_x1;
                    r_end_row       <= n_y1;
                    if (i_action == rdfs_pkg::ACT_DISC) begin
                        r_centre_x <= i_first_x;
                        r_centre_y <= i_first_y;
                        r_rsq      <= rsq_full[rdfs_pkg::RSQ_W-1:0];
                    end
                end
                rdfs_pkg::ACT_TICK: begin
                    if (r_busy) begin
                        if (box_empty || (col_wrap && row_done)) begin
                            r_busy <= 1'b0;
                        end else if (col_wrap) begin
                            r_scan_col <= r_row_start_col;
                            r_scan_row <= row_inc[rdfs_pkg::DIM_W-1:0];
                        end else begin
                            r_scan_col <= col_inc[rdfs_pkg::DIM_W-1:0];
                        end
                    end
                end
                default: ;
            endcase
        end
    end

    rdfs_pixel_pipe u_pipe (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_req          (req),
        .i_frame_width  (r_frame_width),
        .i_out_stall    (i_out_stall),
        .o_hold         (hold),
        .o_out_valid    (o_out_valid),
        .o_pixel_x      (o_pixel_x),
        .o_pixel_y      (o_pixel_y),
        .o_pixel_offset (o_pixel_offset),
        .o_pixel_color  (o_pixel_color),
        .o_write_enable (o_write_enable),
        .o_last         (o_last)
    );

    a_col_not_before_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> (r_scan_col >= r_row_start_col))
        else $error("scan column fell before row start");

    a_empty_tick_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (tick_go && box_empty) |=> !r_busy)
        else $error("empty box did not end the scan");

    a_last_tick_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (tick_go && req.last) |=> !r_busy)
        else $error("final position did not end the scan");

    a_cfg_saturates: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cfg_valid |=> (r_frame_width <= rdfs_pkg::MAX_SIDE) &&
                        (r_frame_height <= rdfs_pkg::MAX_SIDE))
        else $error("frame size above limit");

endmodule

// ----- tb/rect_disc_fill_scanner_tb.sv -----
`timescale 1ns / 100ps
// Self-checking testbench for the rectangle and disc fill scanner: random handshakes, scan prediction.
module rect_disc_fill_scanner_tb;

    localparam int DIM_W   = rdfs_pkg::DIM_W;
    localparam int COORD_W = rdfs_pkg::COORD_W;
    localparam int RAD_W   = rdfs_pkg::RAD_W;
    localparam int OFF_W   = rdfs_pkg::OFF_W;
    localparam int COLOR_W = rdfs_pkg::COLOR_W;

    localparam logic [1:0] ACT_UNUSED = 2'd3;
    localparam int MAX_WAIT = 19;
    localparam int TICK_CAP = 40;

    typedef struct {
        logic [1:0]                action;
        logic signed [COORD_W-1:0] fx;
        logic signed [COORD_W-1:0] fy;
        logic signed [COORD_W-1:0] sx;
        logic signed [COORD_W-1:0] sy;
        logic [RAD_W-1:0]          radius;
        logic [COLOR_W-1:0]        color;
    } t_fill_req;

    typedef struct {
        logic [DIM_W-1:0]   x;
        logic [DIM_W-1:0]   y;
        logic [OFF_W-1:0]   offset;
        logic [COLOR_W-1:0] color;
        logic               we;
        logic               last;
    } t_pixel;

    logic                      i_clk;
    logic                      i_rst_n = 1'b0;
    logic                      i_in_valid = 1'b0;
    logic                      o_in_stall;
    logic [1:0]                i_action = '0;
    logic signed [COORD_W-1:0] i_first_x = '0;
    logic signed [COORD_W-1:0] i_first_y = '0;
    logic signed [COORD_W-1:0] i_second_x = '0;
    logic signed [COORD_W-1:0] i_second_y = '0;
    logic [RAD_W-1:0]          i_radius = '0;
    logic [COLOR_W-1:0]        i_fill_color = '0;
    logic                      o_out_valid;
    logic                      i_out_stall = 1'b0;
    logic [DIM_W-1:0]          o_pixel_x;
    logic [DIM_W-1:0]          o_pixel_y;
    logic [OFF_W-1:0]          o_pixel_offset;
    logic [COLOR_W-1:0]        o_pixel_color;
    logic                      o_write_enable;
    logic                      o_last;
    logic                      i_cfg_valid = 1'b0;
    logic                      o_cfg_ready;
    logic                      i_cfg_index = 1'b0;
    logic [DIM_W-1:0]          i_cfg_data = '0;

    rect_disc_fill_scanner u_dut (.*);

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    initial begin
        #2_000_000;
        $display("status: fail");
        $finish;
    end

    // Scan prediction state
    int        frame_w = 640;
    int        frame_h = 480;
    logic      scan_on = 1'b0;
    logic      scan_disc = 1'b0;
    int        col = 0;
    int        row = 0;
    int        row_first = 0;
    int        col_end = 0;
    int        row_end = 0;
    int        disc_cx = 0;
    int        disc_cy = 0;
    longint    disc_rsq = 0;
    logic [COLOR_W-1:0] fill_word = '0;

    t_fill_req fill_reqs_pending[$];
    t_pixel    pixels_due[$];
    t_fill_req cur_req = '{default: '0};

    logic req_taken = 1'b0;
    logic result_taken = 1'b0;
    int   send_gap = 0;
    int   in_burst = 0;
    int   out_hold = 0;
    int   out_burst = 0;

    int mismatches = 0;
    int reqs_taken = 0;
    int pixels_checked = 0;
    int pixels_written = 0;
    int settings_seen = 1;

    function automatic int clamp_dim(int v, int hi);
        if (v < 0) return 0;
        if (v > hi) return hi;
        return v;
    endfunction

    task automatic load_box(int xa, int ya, int xb, int yb);
        col       = clamp_dim(xa, frame_w);
        row_first = col;
        row       = clamp_dim(ya, frame_h);
        col_end   = clamp_dim(xb, frame_w);
        row_end   = clamp_dim(yb, frame_h);
        scan_on   = 1'b1;
    endtask

    task automatic scan_request(input t_fill_req rq);
        t_pixel px;
        longint dx;
        longint dy;
        int     r;
        r = int'(rq.radius);
        case (rq.action)
            rdfs_pkg::ACT_RECT: begin
                scan_disc = 1'b0;
                fill_word = rq.color;
                load_box(rq.fx, rq.fy, rq.sx, rq.sy);
            end
            rdfs_pkg::ACT_DISC: begin
                scan_disc = 1'b1;
                fill_word = rq.color;
                disc_cx   = rq.fx;
                disc_cy   = rq.fy;
                disc_rsq  = r * r;
                load_box(int'(rq.fx) - r, int'(rq.fy) - r, int'(rq.fx) + r, int'(rq.fy) + r);
            end
            rdfs_pkg::ACT_TICK: begin
                if (scan_on) begin
                    px = '{default: '0};
                    if (col >= col_end || row >= row_end) begin
                        // empty box: one closing result, nothing written
                        px.last = 1'b1;
                        scan_on = 1'b0;
                    end else begin
                        px.x      = DIM_W'(col);
                        px.y      = DIM_W'(row);
                        px.offset = OFF_W'(col + row * frame_w);
                        px.color  = fill_word;
                        px.we     = 1'b1;
                        if (scan_disc) begin
                            dx    = col - disc_cx;
                            dy    = row - disc_cy;
                            px.we = (dx * dx + dy * dy) <= disc_rsq;
                        end
                        px.last = (col + 1 >= col_end) && (row + 1 >= row_end);
                        if (px.last) begin
                            scan_on = 1'b0;
                        end else if (col + 1 >= col_end) begin
                            col = row_first;
                            row = row + 1;
                        end else begin
                            col = col + 1;
                        end
                    end
                    pixels_due.push_back(px);
                end
            end
            default: ;
        endcase
    endtask

    // Mostly random waits, with occasional stretches of back-to-back traffic
    function automatic int draw_wait(inout int burst);
        if (burst > 0) begin
            burst--;
            return 0;
        end
        if ($urandom_range(0, 11) == 0) begin
            burst = $urandom_range(8, 40);
            return 0;
        end
        return $urandom_range(0, MAX_WAIT);
    endfunction

    always @(posedge i_clk) begin : accept
        req_taken = i_rst_n && i_in_valid && !o_in_stall;
        if (req_taken) begin
            scan_request(cur_req);
            reqs_taken++;
        end
    end

    always @(negedge i_clk) begin : drive
        logic show;
        // hold the request until it is taken
        show = i_in_valid && !req_taken;
        if (!show && i_rst_n) begin
            if (send_gap > 0) begin
                send_gap--;
            end else if (fill_reqs_pending.size() > 0) begin
                cur_req  = fill_reqs_pending.pop_front();
                show     = 1'b1;
                send_gap = draw_wait(in_burst);
            end
        end
        i_in_valid   <= show;
        i_action     <= cur_req.action;
        i_first_x    <= cur_req.fx;
        i_first_y    <= cur_req.fy;
        i_second_x   <= cur_req.sx;
        i_second_y   <= cur_req.sy;
        i_radius     <= cur_req.radius;
        i_fill_color <= cur_req.color;
    end

    always @(negedge i_clk) begin : out_stall_drive
        if (result_taken) begin
            out_hold = draw_wait(out_burst);
        end
        if (out_hold > 0) begin
            out_hold--;
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= 1'b0;
        end
    end

    task automatic check_field(input string name, input logic [31:0] want, input logic [31:0] got);
        if (want !== got) begin
            $display("%0t: pixel %s mismatch, expected %0h actual %0h", $time, name, want, got);
            mismatches++;
        end
    endtask

    always @(posedge i_clk) begin : monitor
        t_pixel want;
        result_taken = i_rst_n && o_out_valid && !i_out_stall;
        if (result_taken) begin
            if (pixels_due.size() == 0) begin
                $display("%0t: unexpected pixel, expected none actual x=%0d y=%0d last=%0b",
                         $time, o_pixel_x, o_pixel_y, o_last);
                mismatches++;
            end else begin
                want = pixels_due.pop_front();
                check_field("x", want.x, o_pixel_x);
                check_field("y", want.y, o_pixel_y);
                check_field("offset", want.offset, o_pixel_offset);
                check_field("color", want.color, o_pixel_color);
                check_field("write_enable", want.we, o_write_enable);
                check_field("last", want.last, o_last);
                pixels_checked++;
                if (o_write_enable) pixels_written++;
            end
        end
    end

    function automatic logic [COLOR_W-1:0] pick_color();
        case ($urandom_range(0, 7))
            0: return '0;
            1: return '1;
            default: return $urandom;
        endcase
    endfunction

    function automatic t_fill_req noise_req();
        t_fill_req rq;
        rq.action = 2'($urandom);
        rq.fx     = COORD_W'($urandom);
        rq.fy     = COORD_W'($urandom);
        rq.sx     = COORD_W'($urandom);
        rq.sy     = COORD_W'($urandom);
        rq.radius = RAD_W'($urandom);
        rq.color  = pick_color();
        return rq;
    endfunction

    task automatic add_start(input logic [1:0] act, input int fx, input int fy, input int sx,
                             input int sy, input int r, input logic [COLOR_W-1:0] color);
        t_fill_req rq;
        rq        = noise_req();
        rq.action = act;
        rq.fx     = COORD_W'(fx);
        rq.fy     = COORD_W'(fy);
        if (act == rdfs_pkg::ACT_RECT) begin
            rq.sx = COORD_W'(sx);
            rq.sy = COORD_W'(sy);
        end else begin
            rq.radius = RAD_W'(r);
        end
        rq.color = color;
        fill_reqs_pending.push_back(rq);
    endtask

    task automatic add_ticks(input int n);
        t_fill_req rq;
        repeat (n) begin
            rq        = noise_req();
            rq.action = rdfs_pkg::ACT_TICK;
            fill_reqs_pending.push_back(rq);
        end
    endtask

    // Number of ticks that walk the clipped box to its end
    function automatic int box_ticks(int x0, int y0, int x1, int y1);
        int nx;
        int ny;
        nx = clamp_dim(x1, frame_w) - clamp_dim(x0, frame_w);
        ny = clamp_dim(y1, frame_h) - clamp_dim(y0, frame_h);
        if (nx <= 0 || ny <= 0) return 1;
        return nx * ny;
    endfunction

    task automatic add_sequence();
        t_fill_req rq;
        int kind;
        int x0;
        int y0;
        int x1;
        int y1;
        int r;
        int n;
        kind = $urandom_range(0, 9);
        if (kind == 0) begin
            rq = noise_req();
            fill_reqs_pending.push_back(rq);
        end else if (kind == 1) begin
            // start with wild coordinates, then a few ticks
            rq = noise_req();
            rq.action = $urandom_range(0, 1) ? rdfs_pkg::ACT_RECT : rdfs_pkg::ACT_DISC;
            fill_reqs_pending.push_back(rq);
            add_ticks($urandom_range(0, 6));
        end else begin
            if ($urandom_range(0, 1)) begin
                x0 = $urandom_range(0, frame_w + 4) - 3;
                y0 = $urandom_range(0, frame_h + 4) - 3;
                x1 = x0 + $urandom_range(0, 7) - 1;
                y1 = y0 + $urandom_range(0, 6) - 1;
                add_start(rdfs_pkg::ACT_RECT, x0, y0, x1, y1, 0, pick_color());
            end else begin
                x0 = $urandom_range(0, frame_w + 5) - 3;
                y0 = $urandom_range(0, frame_h + 5) - 3;
                r  = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 2047) : $urandom_range(0, 4);
                add_start(rdfs_pkg::ACT_DISC, x0, y0, 0, 0, r, pick_color());
                x1 = x0 + r;
                y1 = y0 + r;
                x0 = x0 - r;
                y0 = y0 - r;
            end
            n = box_ticks(x0, y0, x1, y1);
            // now and then cut the scan short so the next start abandons it
            if ($urandom_range(0, 4) == 0) n = $urandom_range(0, n);
            else n = n + $urandom_range(0, 1);
            if (n > TICK_CAP) n = TICK_CAP;
            add_ticks(n);
        end
    endtask

    task automatic wait_drained();
        do @(posedge i_clk);
        while (fill_reqs_pending.size() != 0 || i_in_valid || pixels_due.size() != 0);
        repeat (6) @(posedge i_clk);
    endtask

    task automatic write_dim(input rdfs_pkg::t_cfg_index idx, input logic [DIM_W-1:0] data);
        int v;
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk);
        while (!o_cfg_ready);
        v = (data > rdfs_pkg::MAX_SIDE) ? int'(rdfs_pkg::MAX_SIDE) : int'(data);
        if (idx == rdfs_pkg::CFG_FRAME_WIDTH) frame_w = v;
        else frame_h = v;
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic run_phase(input logic [DIM_W-1:0] w, input logic [DIM_W-1:0] h, input int n);
        wait_drained();
        write_dim(rdfs_pkg::CFG_FRAME_WIDTH, w);
        write_dim(rdfs_pkg::CFG_FRAME_HEIGHT, h);
        settings_seen++;
        while (fill_reqs_pending.size() < n) add_sequence();
    endtask

    initial begin : stimulus
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // idle tick and the unused action code: no result
        add_ticks(1);
        add_start(ACT_UNUSED, 0, 0, 0, 0, 0, '1);
        // corners at the negative extreme, clipped to the frame origin
        add_start(rdfs_pkg::ACT_RECT, -4096, -4096, 2, 1, 0, '1);
        add_ticks(3);
        // corners at the positive extreme, reversed: empty box
        add_start(rdfs_pkg::ACT_RECT, 4095, 4095, -4096, -4096, 0, 32'h5A5A_A5A5);
        add_ticks(1);
        // small disc, corners outside the circle
        add_start(rdfs_pkg::ACT_DISC, 1, 1, 0, 0, 1, '0);
        add_ticks(4);
        // zero radius and largest radius, both empty after clipping
        add_start(rdfs_pkg::ACT_DISC, 100, 50, 0, 0, 0, 32'h1234_5678);
        add_ticks(1);
        add_start(rdfs_pkg::ACT_DISC, 4095, -4096, 0, 0, 2047, 32'h8000_0001);
        add_ticks(1);
        // start while busy drops the running rectangle
        add_start(rdfs_pkg::ACT_RECT, 10, 10, 12, 12, 0, 32'hCAFE_0001);
        add_ticks(1);
        add_start(rdfs_pkg::ACT_DISC, 639, 479, 0, 0, 1, 32'h0BAD_F00D);
        add_ticks(4);

        run_phase(12'd16, 12'd12, 50);
        run_phase(12'd4095, 12'd2048, 50);
        run_phase(12'd1, 12'd1, 50);
        run_phase(12'd0, 12'd7, 50);
        run_phase(12'd33, 12'd0, 50);
        run_phase(DIM_W'($urandom_range(1, 64)), DIM_W'($urandom_range(1, 64)), 50);
        run_phase(12'd640, 12'd480, 50);
        run_phase(DIM_W'($urandom), DIM_W'($urandom), 50);
        wait_drained();

        $display("Covered %0d requests across %0d frame settings: %0d pixels checked, %0d written.",
                 reqs_taken, settings_seen, pixels_checked, pixels_written);
        if (mismatches == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
